FILE: hw/rtl/fbt_pkg.sv
// ---------------------------------------------------------------------------
// fbt_pkg - shared types and constants of the firmware block tracker
// Sizes of the image and bitmap, message and result codes, and the command
// bundle passed from the controller to the bitmap memory.
// ---------------------------------------------------------------------------
package fbt_pkg;

   // Image geometry
   localparam int unsigned BLOCK_BYTES  = 64;
   localparam int unsigned BLOCK_COUNT  = 512;
   localparam int unsigned MAX_IDS      = 32;
   localparam int unsigned HEADER_BYTES = 4;
   localparam int unsigned DATA_OVERHEAD = 6;
   localparam int unsigned DATA_LEN     = DATA_OVERHEAD + BLOCK_BYTES;
   localparam int unsigned FILE_BYTES   = BLOCK_BYTES * BLOCK_COUNT;

   // Bitmap organisation: 32-bit rows; BLOCK_COUNT is a multiple of WORD_W
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned WORD_IDX_W = $clog2(WORD_W);
   localparam int unsigned ROWS       = BLOCK_COUNT / WORD_W;
   localparam int unsigned ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned BLK_W      = $clog2(BLOCK_COUNT);
   localparam int unsigned CNT_W      = BLK_W + 1;
   localparam int unsigned ID_CNT_W   = $clog2(MAX_IDS + 1);

   // Field widths
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned COMP_W  = 8;
   localparam int unsigned LEN_W   = 8;
   localparam int unsigned IDX_W   = 16;
   localparam int unsigned VER_W   = 16;
   localparam int unsigned ILEN_W  = 16;
   localparam int unsigned CRC_W   = 32;
   localparam int unsigned RK_W    = 3;
   localparam int unsigned PROG_W  = 7;
   localparam int unsigned PROD_W  = CNT_W + PROG_W;
   localparam int unsigned PROG_MAX = 100;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_OWN_COMPONENT = '0;

   // Message kinds
   localparam logic [KIND_W-1:0] MSG_DATA    = 2'd0;
   localparam logic [KIND_W-1:0] MSG_CHECK   = 2'd1;
   localparam logic [KIND_W-1:0] MSG_UPDATE  = 2'd2;
   localparam logic [KIND_W-1:0] MSG_UNKNOWN = 2'd3;

   // Result kinds
   localparam logic [RK_W-1:0] RK_STATUS  = 3'd0;
   localparam logic [RK_W-1:0] RK_STORE   = 3'd1;
   localparam logic [RK_W-1:0] RK_MISSING = 3'd2;
   localparam logic [RK_W-1:0] RK_READY   = 3'd3;
   localparam logic [RK_W-1:0] RK_START   = 3'd4;

   // Tracking phases
   localparam logic [1:0] PH_INIT  = 2'd0;
   localparam logic [1:0] PH_RECV  = 2'd1;
   localparam logic [1:0] PH_READY = 2'd2;

   // Bitmap memory command
   typedef struct packed {
      logic              clr;
      logic              wr_en;
      logic [ROW_W-1:0]  wr_row;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [ROW_W-1:0]  rd_row;
   } mem_cmd_type;

   // Position of the lowest set bit of a row word
   function automatic logic [WORD_IDX_W-1:0] lowest_set(input logic [WORD_W-1:0] word);
      logic [WORD_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            idx = WORD_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

FILE: hw/rtl/fbt_bitmap_mem.sv
// ---------------------------------------------------------------------------
// fbt_bitmap_mem - received-block bitmap
// One row of 32 received flags per memory word, synchronous read. A valid
// flop per row lets a clear take effect at once: a row not written since the
// last clear reads as all zero.
// ---------------------------------------------------------------------------
module fbt_bitmap_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  fbt_pkg::mem_cmd_type        cmd,
   output logic [fbt_pkg::WORD_W-1:0]  rd_word
);

   logic [fbt_pkg::WORD_W-1:0] mem [fbt_pkg::ROWS];
   logic [fbt_pkg::ROWS-1:0]   row_valid_ff;
   logic [fbt_pkg::ROWS-1:0]   row_valid_in;
   logic [fbt_pkg::WORD_W-1:0] rd_data_ff;
   logic                       rd_hit_ff;

   // Row valid flags: clear drops all, a write marks its row
   always_comb begin
      row_valid_in = row_valid_ff;
      if (cmd.clr) begin
         row_valid_in = '0;
      end
      if (cmd.wr_en) begin
         row_valid_in[cmd.wr_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   // Storage write
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_row] <= cmd.wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_row];
         rd_hit_ff  <= row_valid_ff[cmd.rd_row];
      end
   end

   assign rd_word = rd_hit_ff ? rd_data_ff : '0;

endmodule

FILE: hw/rtl/fbt_ctrl.sv
// ---------------------------------------------------------------------------
// fbt_ctrl - message sequencer of the firmware block tracker
// Screens each message, runs the read-modify-write of the bitmap for data
// blocks, walks the bitmap row by row for missing IDs, holds the tracking
// state and drives the registered result channel.
// ---------------------------------------------------------------------------
module fbt_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fbt_pkg::COMP_W-1:0]        own_component,
   // input beats
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fbt_pkg::KIND_W-1:0]        req_kind,
   input  logic                              req_is_fw_message,
   input  logic [fbt_pkg::COMP_W-1:0]        req_target_comp,
   input  logic [fbt_pkg::LEN_W-1:0]         req_msg_len,
   input  logic [fbt_pkg::IDX_W-1:0]         req_block_index,
   input  logic [fbt_pkg::VER_W-1:0]         req_image_version,
   input  logic [fbt_pkg::ILEN_W-1:0]        req_image_length,
   input  logic [fbt_pkg::CRC_W-1:0]         req_expected_crc,
   input  logic [fbt_pkg::CRC_W-1:0]         req_computed_crc,
   // result beats
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fbt_pkg::RK_W-1:0]          rsp_result_kind,
   output logic [fbt_pkg::BLK_W-1:0]         rsp_block_number,
   output logic [fbt_pkg::VER_W-1:0]         rsp_notice_version,
   output logic [fbt_pkg::PROG_W-1:0]        rsp_progress_percent,
   output logic                              rsp_status,
   output logic                              rsp_last,
   // bitmap memory
   output fbt_pkg::mem_cmd_type              mem_cmd,
   input  logic [fbt_pkg::WORD_W-1:0]        rd_word
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_DATA      = 4'd2;
   localparam logic [3:0] S_SCAN_RD   = 4'd3;
   localparam logic [3:0] S_SCAN_LOAD = 4'd4;
   localparam logic [3:0] S_SCAN_EMIT = 4'd5;
   localparam logic [3:0] S_CMD       = 4'd6;
   localparam logic [3:0] S_STATUS    = 4'd7;

   logic [3:0] state_ff, state_in;

   // latched message
   logic [fbt_pkg::KIND_W-1:0] kind_ff;
   logic                       isfw_ff;
   logic [fbt_pkg::COMP_W-1:0] comp_ff;
   logic [fbt_pkg::LEN_W-1:0]  plen_ff;
   logic [fbt_pkg::IDX_W-1:0]  blk_ff;
   logic [fbt_pkg::VER_W-1:0]  ver_ff;
   logic [fbt_pkg::ILEN_W-1:0] ilen_ff;
   logic [fbt_pkg::CRC_W-1:0]  ecrc_ff;
   logic [fbt_pkg::CRC_W-1:0]  ccrc_ff;

   // tracking state
   logic [1:0]                 phase_ff, phase_in;
   logic [fbt_pkg::VER_W-1:0]  version_ff, version_in;
   logic [fbt_pkg::CNT_W-1:0]  count_ff, count_in;

   // per-message working registers
   logic                        fail_ff, fail_in;
   logic [fbt_pkg::RK_W-1:0]    cmd_kind_ff, cmd_kind_in;
   logic [fbt_pkg::BLK_W-1:0]   cmd_blk_ff, cmd_blk_in;
   logic [fbt_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [fbt_pkg::ID_CNT_W-1:0] ids_ff, ids_in;
   logic [fbt_pkg::WORD_W-1:0]  miss_ff, miss_in;

   // result register
   logic                        out_valid_ff;
   logic [fbt_pkg::RK_W-1:0]    out_kind_ff;
   logic [fbt_pkg::BLK_W-1:0]   out_blk_ff;
   logic [fbt_pkg::VER_W-1:0]   out_ver_ff;
   logic [fbt_pkg::PROG_W-1:0]  out_prog_ff;
   logic                        out_status_ff;
   logic                        out_last_ff;

   logic                        emit;
   logic [fbt_pkg::RK_W-1:0]    emit_kind;
   logic [fbt_pkg::BLK_W-1:0]   emit_blk;
   logic                        emit_status;
   logic                        emit_last;
   logic                        out_free;

   logic                        accept;
   logic                        screen_ok;
   logic                        data_ok;
   logic                        clearing;
   logic                        seen;
   logic [fbt_pkg::WORD_IDX_W-1:0] bit_pos;
   logic [fbt_pkg::WORD_W-1:0]  onehot;
   logic [fbt_pkg::WORD_W-1:0]  base_word;
   logic [fbt_pkg::WORD_IDX_W-1:0] miss_pos;
   logic [fbt_pkg::PROD_W-1:0]  prog_prod;
   logic [fbt_pkg::PROG_W-1:0]  progress;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // message screening
   assign screen_ok = isfw_ff && (32'(plen_ff) >= fbt_pkg::HEADER_BYTES)
                      && (comp_ff == own_component);
   assign data_ok   = (32'(plen_ff) == fbt_pkg::DATA_LEN)
                      && (32'(blk_ff) < fbt_pkg::BLOCK_COUNT);

   // bitmap update terms
   assign clearing  = (phase_ff == fbt_pkg::PH_INIT) || (ver_ff != version_ff);
   assign bit_pos   = blk_ff[fbt_pkg::WORD_IDX_W-1:0];
   assign onehot    = fbt_pkg::WORD_W'(1) << bit_pos;
   assign base_word = clearing ? '0 : rd_word;
   assign seen      = base_word[bit_pos];
   assign miss_pos  = fbt_pkg::lowest_set(miss_ff);

   // progress = count * 100 / BLOCK_COUNT, capped
   assign prog_prod = fbt_pkg::PROD_W'(count_ff) * fbt_pkg::PROD_W'(fbt_pkg::PROG_MAX);
   always_comb begin
      if ((prog_prod >> fbt_pkg::BLK_W) > fbt_pkg::PROD_W'(fbt_pkg::PROG_MAX)) begin
         progress = fbt_pkg::PROG_W'(fbt_pkg::PROG_MAX);
      end else begin
         progress = fbt_pkg::PROG_W'(prog_prod >> fbt_pkg::BLK_W);
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      version_in  = version_ff;
      count_in    = count_ff;
      fail_in     = fail_ff;
      cmd_kind_in = cmd_kind_ff;
      cmd_blk_in  = cmd_blk_ff;
      row_in      = row_ff;
      ids_in      = ids_ff;
      miss_in     = miss_ff;
      mem_cmd     = '0;
      emit        = 1'b0;
      emit_kind   = fbt_pkg::RK_STATUS;
      emit_blk    = '0;
      emit_status = 1'b0;
      emit_last   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            fail_in  = 1'b1;
            state_in = S_STATUS;
            if (screen_ok) begin
               case (kind_ff)
                  fbt_pkg::MSG_DATA: begin
                     if (data_ok) begin
                        // fetch the row holding this block's flag
                        fail_in        = 1'b0;
                        mem_cmd.rd_en  = 1'b1;
                        mem_cmd.rd_row = blk_ff[fbt_pkg::BLK_W-1:fbt_pkg::WORD_IDX_W];
                        state_in       = S_DATA;
                     end
                  end
                  fbt_pkg::MSG_CHECK: begin
                     fail_in = 1'b0;
                     if (phase_ff == fbt_pkg::PH_READY) begin
                        cmd_kind_in = fbt_pkg::RK_READY;
                        cmd_blk_in  = '0;
                        state_in    = S_CMD;
                     end else if (32'(ilen_ff) != fbt_pkg::FILE_BYTES) begin
                        state_in = S_STATUS;
                     end else if (32'(count_ff) < fbt_pkg::BLOCK_COUNT) begin
                        row_in   = '0;
                        ids_in   = '0;
                        state_in = S_SCAN_RD;
                     end else if (ecrc_ff != ccrc_ff) begin
                        phase_in = fbt_pkg::PH_INIT;
                        state_in = S_STATUS;
                     end else begin
                        phase_in    = fbt_pkg::PH_READY;
                        cmd_kind_in = fbt_pkg::RK_READY;
                        cmd_blk_in  = '0;
                        state_in    = S_CMD;
                     end
                  end
                  fbt_pkg::MSG_UPDATE: begin
                     if (phase_ff == fbt_pkg::PH_READY) begin
                        fail_in     = 1'b0;
                        cmd_kind_in = fbt_pkg::RK_START;
                        cmd_blk_in  = '0;
                        state_in    = S_CMD;
                     end
                  end
                  default: begin
                     fail_in = 1'b1;
                  end
               endcase
            end
         end

         S_DATA: begin
            // new version or first block: restart tracking
            if (clearing) begin
               mem_cmd.clr = 1'b1;
               phase_in    = fbt_pkg::PH_RECV;
               version_in  = ver_ff;
               count_in    = '0;
            end
            state_in = S_STATUS;
            if (clearing || (phase_ff != fbt_pkg::PH_READY)) begin
               if (!seen) begin
                  mem_cmd.wr_en   = 1'b1;
                  mem_cmd.wr_row  = blk_ff[fbt_pkg::BLK_W-1:fbt_pkg::WORD_IDX_W];
                  mem_cmd.wr_data = base_word | onehot;
                  count_in        = (clearing ? '0 : count_ff) + fbt_pkg::CNT_W'(1);
                  cmd_kind_in     = fbt_pkg::RK_STORE;
                  cmd_blk_in      = blk_ff[fbt_pkg::BLK_W-1:0];
                  state_in        = S_CMD;
               end
            end
         end

         S_SCAN_RD: begin
            mem_cmd.rd_en  = 1'b1;
            mem_cmd.rd_row = row_ff;
            state_in       = S_SCAN_LOAD;
         end

         S_SCAN_LOAD: begin
            miss_in  = ~rd_word;
            state_in = S_SCAN_EMIT;
         end

         S_SCAN_EMIT: begin
            if (miss_ff == '0) begin
               if (row_ff == fbt_pkg::ROW_W'(fbt_pkg::ROWS - 1)) begin
                  state_in = S_STATUS;
               end else begin
                  row_in   = row_ff + fbt_pkg::ROW_W'(1);
                  state_in = S_SCAN_RD;
               end
            end else if (out_free) begin
               // one missing ID per beat, lowest first
               emit      = 1'b1;
               emit_kind = fbt_pkg::RK_MISSING;
               emit_blk  = fbt_pkg::BLK_W'({row_ff, miss_pos});
               miss_in   = miss_ff & ~(fbt_pkg::WORD_W'(1) << miss_pos);
               ids_in    = ids_ff + fbt_pkg::ID_CNT_W'(1);
               if (ids_ff == fbt_pkg::ID_CNT_W'(fbt_pkg::MAX_IDS - 1)) begin
                  state_in = S_STATUS;
               end
            end
         end

         S_CMD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = cmd_kind_ff;
               emit_blk  = cmd_blk_ff;
               state_in  = S_STATUS;
            end
         end

         S_STATUS: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_kind   = fbt_pkg::RK_STATUS;
               emit_status = fail_ff;
               emit_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= fbt_pkg::PH_INIT;
         version_ff <= '0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         version_ff <= version_in;
         count_ff   <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      fail_ff     <= fail_in;
      cmd_kind_ff <= cmd_kind_in;
      cmd_blk_ff  <= cmd_blk_in;
      row_ff      <= row_in;
      ids_ff      <= ids_in;
      miss_ff     <= miss_in;
   end

   // message capture
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         isfw_ff <= req_is_fw_message;
         comp_ff <= req_target_comp;
         plen_ff <= req_msg_len;
         blk_ff  <= req_block_index;
         ver_ff  <= req_image_version;
         ilen_ff <= req_image_length;
         ecrc_ff <= req_expected_crc;
         ccrc_ff <= req_computed_crc;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff   <= emit_kind;
         out_blk_ff    <= emit_blk;
         out_ver_ff    <= version_ff;
         out_prog_ff   <= progress;
         out_status_ff <= emit_status;
         out_last_ff   <= emit_last;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_result_kind      = out_kind_ff;
   assign rsp_block_number     = out_blk_ff;
   assign rsp_notice_version   = out_ver_ff;
   assign rsp_progress_percent = out_prog_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_last             = out_last_ff;

endmodule

FILE: hw/rtl/firmware_block_tracker.sv
// ---------------------------------------------------------------------------
// firmware_block_tracker - reception tracker for a block-wise firmware image
// Takes one message at a time: a data block is decoded, its bitmap row read
// and updated, then it sends a store beat if the block is new and its status
// beat; a start or rejected message goes from decode to its beats. A check
// walks the 512-entry bitmap one 32-bit row per memory read, with read, load
// and emit steps per row and one emit per missing ID listed, up to 32 IDs.
// Results leave through an output register, so the next message is taken
// while the final beat of the previous one waits. No clearing pass is needed
// after reset or a version change: each bitmap row has a valid flag, and one clear drops them all.
// ---------------------------------------------------------------------------
module firmware_block_tracker (
   input  logic                                clock,
   input  logic                                reset,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fbt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fbt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fbt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fbt_pkg::KIND_W-1:0]          req_kind,
   input  logic                                req_is_fw_message,
   input  logic [fbt_pkg::COMP_W-1:0]          req_target_comp,
   input  logic [fbt_pkg::LEN_W-1:0]           req_msg_len,
   input  logic [fbt_pkg::IDX_W-1:0]           req_block_index,
   input  logic [fbt_pkg::VER_W-1:0]           req_image_version,
   input  logic [fbt_pkg::ILEN_W-1:0]          req_image_length,
   input  logic [fbt_pkg::CRC_W-1:0]           req_expected_crc,
   input  logic [fbt_pkg::CRC_W-1:0]           req_computed_crc,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fbt_pkg::RK_W-1:0]            rsp_result_kind,
   output logic [fbt_pkg::BLK_W-1:0]           rsp_block_number,
   output logic [fbt_pkg::VER_W-1:0]           rsp_notice_version,
   output logic [fbt_pkg::PROG_W-1:0]          rsp_progress_percent,
   output logic                                rsp_status,
   output logic                                rsp_last
);

   logic [fbt_pkg::COMP_W-1:0]     own_component_ff;
   logic [fbt_pkg::CSR_ADDR_W-3:0] csr_index;
   logic                           csr_write;
   fbt_pkg::mem_cmd_type           mem_cmd;
   logic [fbt_pkg::WORD_W-1:0]     rd_word;

   // register file: own component ID
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[fbt_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_component_ff <= '0;
      end else if (csr_write && (csr_index == fbt_pkg::REG_OWN_COMPONENT)) begin
         own_component_ff <= csr_pwdata[fbt_pkg::COMP_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == fbt_pkg::REG_OWN_COMPONENT) begin
         csr_prdata = fbt_pkg::CSR_DATA_W'(own_component_ff);
      end
   end

   fbt_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .own_component        (own_component_ff),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_is_fw_message    (req_is_fw_message),
      .req_target_comp      (req_target_comp),
      .req_msg_len          (req_msg_len),
      .req_block_index      (req_block_index),
      .req_image_version    (req_image_version),
      .req_image_length     (req_image_length),
      .req_expected_crc     (req_expected_crc),
      .req_computed_crc     (req_computed_crc),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_block_number     (rsp_block_number),
      .rsp_notice_version   (rsp_notice_version),
      .rsp_progress_percent (rsp_progress_percent),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last),
      .mem_cmd              (mem_cmd),
      .rd_word              (rd_word)
   );

   fbt_bitmap_mem u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .rd_word (rd_word)
   );

`ifndef SYNTHESIS
   // one message at a time: an accepted beat blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a message was in work");

   // the closing beat of a message is always its status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_result_kind == fbt_pkg::RK_STATUS))
      else $error("last beat is not a status result");

   // command beats never carry a failure
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !rsp_status)
      else $error("failed status on a command beat");

   // progress stays within percent range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_progress_percent <= fbt_pkg::PROG_W'(fbt_pkg::PROG_MAX)))
      else $error("progress above 100 percent");
`endif

endmodule
